// ===== hdl/ackfb_pkg.sv =====
`timescale 1ns / 1ps
// ackfb_pkg: shared types, constants and crc helper for the ack frame builder
// used by every module under hdl/ but ackfb_checker, depends on nothing

package ackfb_pkg;

  localparam int unsigned FrameLen = 24;
  localparam int unsigned CrcSpan  = 20;
  localparam int unsigned PosW     = $clog2(FrameLen);

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  // allowed status codes
  localparam logic [7:0] StatusAck = 8'h06;
  localparam logic [7:0] StatusNak = 8'h15;
  localparam logic [7:0] StatusCan = 8'h18;

  // frame header bytes
  localparam logic [7:0] MagicF   = 8'h46;
  localparam logic [7:0] MagicT   = 8'h54;
  localparam logic [7:0] MagicA   = 8'h41;
  localparam logic [7:0] FrameVer = 8'h01;

  // byte positions inside the frame
  localparam int unsigned PosIndex  = 4;
  localparam int unsigned PosStatus = 8;
  localparam int unsigned PosPad    = 9;
  localparam int unsigned PosOffset = 12;

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    logic        reject;
    logic [31:0] blk_num;
    logic [7:0]  status_code;
    logic [63:0] commit_ofs;
  } ack_entry_t;

  // front -> queue
  typedef struct packed {
    logic       push;
    ack_entry_t entry;
  } ack_push_t;

  // queue -> back
  typedef struct packed {
    logic       valid;
    ack_entry_t entry;
  } ack_head_t;

  function automatic logic status_ok(input logic [7:0] st);
    return (st == StatusAck) || (st == StatusNak) || (st == StatusCan);
  endfunction

  // reflected crc-32, one byte folded in bit by bit
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hdl/ack_frame_builder_crc32.sv =====
`timescale 1ns / 1ps
// path: an accepted transaction is written into the queue, then loaded into the output register,
// which presents its first result byte; a frame leaves as 24 bytes and a rejected status as one,
//   one byte at a time through the output register, which holds while out_stall_i is high
// reset: rst_ni asynchronous active low, empties the queue and the output register
// depends on ackfb_pkg, ackfb_front, ackfb_queue, ackfb_back

module ack_frame_builder_crc32 #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] blk_num_i,
  input  logic [7:0]  status_code_i,
  input  logic [63:0] commit_ofs_i,
  // frame byte channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  output logic        rejected_o
);

  ackfb_pkg::ack_push_t push;
  ackfb_pkg::ack_head_t head;
  logic                 queue_full;
  logic                 pop;

  // front: takes a request transaction and flags a disallowed status
  ackfb_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .blk_num_i     (blk_num_i),
    .status_code_i (status_code_i),
    .commit_ofs_i  (commit_ofs_i),
    .queue_full_i  (queue_full),
    .push_o        (push)
  );

  // queue: decouples request intake from byte output so new requests land
  // while a frame is still streaming out
  ackfb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .head_o (head),
    .pop_i  (pop)
  );

  // back: walks the 24 frame positions, folds bytes 0..19 into the crc and
  // sends the inverted crc little-endian in the last four bytes; a rejected
  // request leaves as one byte with last and rejected set
  ackfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o),
    .rejected_o   (rejected_o)
  );

endmodule

// ===== hdl/ackfb_front.sv =====
`timescale 1ns / 1ps
// ackfb_front: input side, takes a transaction and classifies its status
// depends on ackfb_pkg

module ackfb_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           blk_num_i,
  input  logic [7:0]            status_code_i,
  input  logic [63:0]           commit_ofs_i,
  input  logic                  queue_full_i,
  output ackfb_pkg::ack_push_t  push_o
);

  assign in_stall_o = queue_full_i;

  always_comb begin
    push_o.push             = in_valid_i && !queue_full_i;
    push_o.entry.reject     = !ackfb_pkg::status_ok(status_code_i);
    push_o.entry.blk_num    = blk_num_i;
    push_o.entry.status_code = status_code_i;
    push_o.entry.commit_ofs = commit_ofs_i;
  end

endmodule

// ===== hdl/ackfb_queue.sv =====
`timescale 1ns / 1ps
// ackfb_queue: short fifo of classified requests between front and back
// depends on ackfb_pkg

module ackfb_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ackfb_pkg::ack_push_t  push_i,
  output logic                  full_o,
  output ackfb_pkg::ack_head_t  head_o,
  input  logic                  pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ackfb_pkg::ack_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == CntW'(Depth));
  assign head_o.valid = (count_q != '0);
  assign head_o.entry = mem_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.entry;
    end
  end

endmodule

// ===== hdl/ackfb_back.sv =====
`timescale 1ns / 1ps
// ackfb_back: serializes the queue head into frame bytes, runs the crc
// depends on ackfb_pkg

module ackfb_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ackfb_pkg::ack_head_t  head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            frame_byte_o,
  output logic                  last_byte_o,
  output logic                  rejected_o
);

  ackfb_pkg::pos_t pos_q, pos_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q;
  logic            last_q, rej_q;
  logic [31:0]     crc_q, crc_base, crc_fin;
  logic [7:0]      sel_byte;
  logic            load, at_end;
  logic [2:0]      off_sel;

  assign load    = head_i.valid && (!out_valid_q || !out_stall_i);
  assign at_end  = (pos_q == ackfb_pkg::pos_t'(ackfb_pkg::FrameLen - 1));
  assign pop_o   = load && (head_i.entry.reject || at_end);
  assign crc_fin = ~crc_q;
  assign off_sel = 3'(pos_q - ackfb_pkg::pos_t'(ackfb_pkg::PosOffset));
  assign crc_base = (pos_q == '0) ? ackfb_pkg::CrcInit : crc_q;

  // byte at the current frame position
  always_comb begin
    sel_byte = 8'h00;
    priority if (pos_q < ackfb_pkg::pos_t'(ackfb_pkg::PosIndex)) begin
      unique case (pos_q[1:0])
        2'd0:    sel_byte = ackfb_pkg::MagicF;
        2'd1:    sel_byte = ackfb_pkg::MagicT;
        2'd2:    sel_byte = ackfb_pkg::MagicA;
        default: sel_byte = ackfb_pkg::FrameVer;
      endcase
    end else if (pos_q < ackfb_pkg::pos_t'(ackfb_pkg::PosStatus)) begin
      sel_byte = head_i.entry.blk_num[{pos_q[1:0], 3'b000} +: 8];
    end else if (pos_q == ackfb_pkg::pos_t'(ackfb_pkg::PosStatus)) begin
      sel_byte = head_i.entry.status_code;
    end else if (pos_q < ackfb_pkg::pos_t'(ackfb_pkg::PosOffset)) begin
      sel_byte = 8'h00;
    end else if (pos_q < ackfb_pkg::pos_t'(ackfb_pkg::CrcSpan)) begin
      sel_byte = head_i.entry.commit_ofs[{off_sel, 3'b000} +: 8];
    end else begin
      sel_byte = crc_fin[{pos_q[1:0], 3'b000} +: 8];
    end
  end

  always_comb begin
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
      if (!head_i.entry.reject) begin
        pos_d = at_end ? '0 : pos_q + 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.entry.reject ? 8'h00 : sel_byte;
      last_q <= head_i.entry.reject || at_end;
      rej_q  <= head_i.entry.reject;
      if (!head_i.entry.reject && (pos_q < ackfb_pkg::pos_t'(ackfb_pkg::CrcSpan))) begin
        crc_q <= ackfb_pkg::crc32_byte(crc_base, sel_byte);
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = byte_q;
  assign last_byte_o  = last_q;
  assign rejected_o   = rej_q;

endmodule

// ===== hdl/ackfb_checker.sv =====
`timescale 1ns / 1ps
// ackfb_checker: port-level checks on the frame byte channel
// depends on ack_frame_builder_crc32 ports, bound below

module ackfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic       last_byte_o,
  input logic       rejected_o
);

  // a reject is a lone zero byte that closes its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rejected_o) |-> (last_byte_o && (frame_byte_o == 8'h00)))
    else $error("reject result not a single zero last byte");

  // frame bytes stream without gaps and never turn into a reject midway
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_byte_o) |=> (out_valid_o && !rejected_o))
    else $error("gap or reject inside a frame");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(frame_byte_o) && $stable(last_byte_o) && $stable(rejected_o)))
    else $error("stalled result changed");

endmodule

bind ack_frame_builder_crc32 ackfb_checker u_ackfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o),
  .rejected_o   (rejected_o)
);

// ===== sim/ack_frame_builder_crc32_test.sv =====
`timescale 1ns / 1ps
// ack_frame_builder_crc32_test: self-checking bench for the crc-32 ack frame builder
// drives requests, predicts every frame byte and compares; needs ackfb_pkg and the rtl

module ack_frame_builder_crc32_test;

  // long receiver hold-off so the request queue fills and stalls the sender
  localparam int unsigned HoldOffCycles = 300;
  // the request queue is two deep; settling time after the ledger has checked its last byte
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomItems   = 152;

  // one expected transaction on the frame byte channel
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       rejected;
  } ack_byte_t;

  // builds the expected frame bytes per request and checks them in order
  class ack_byte_ledger;
    ack_byte_t   pending_bytes[$];
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned frames_noted;
    int unsigned rejects_noted;

    function void note_request(logic [31:0] idx, logic [7:0] st, logic [63:0] off);
      logic [7:0]  frame [ackfb_pkg::FrameLen];
      logic [31:0] crc;
      ack_byte_t   b;
      if (!(st == ackfb_pkg::StatusAck || st == ackfb_pkg::StatusNak ||
            st == ackfb_pkg::StatusCan)) begin
        // unknown status: one reject beat, no frame
        b.data = 8'h00;
        b.last = 1'b1;
        b.rejected = 1'b1;
        pending_bytes.push_back(b);
        rejects_noted++;
        return;
      end
      foreach (frame[i]) frame[i] = 8'h00;
      frame[0] = ackfb_pkg::MagicF;
      frame[1] = ackfb_pkg::MagicT;
      frame[2] = ackfb_pkg::MagicA;
      frame[3] = ackfb_pkg::FrameVer;
      for (int i = 0; i < 4; i++) frame[ackfb_pkg::PosIndex + i] = idx[8*i +: 8];
      frame[ackfb_pkg::PosStatus] = st;
      for (int i = 0; i < 8; i++) frame[ackfb_pkg::PosOffset + i] = off[8*i +: 8];
      // reflected crc, fed one data bit at a time, lsb first
      crc = ackfb_pkg::CrcInit;
      for (int i = 0; i < ackfb_pkg::CrcSpan; i++) begin
        for (int k = 0; k < 8; k++) begin
          crc = (crc[0] ^ frame[i][k]) ? ((crc >> 1) ^ ackfb_pkg::CrcPoly) : (crc >> 1);
        end
      end
      crc = ~crc;
      for (int i = 0; i < 4; i++) frame[ackfb_pkg::CrcSpan + i] = crc[8*i +: 8];
      for (int i = 0; i < ackfb_pkg::FrameLen; i++) begin
        b.data = frame[i];
        b.last = (i == ackfb_pkg::FrameLen - 1);
        b.rejected = 1'b0;
        pending_bytes.push_back(b);
      end
      frames_noted++;
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic rejected);
      ack_byte_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $error("unexpected frame byte %02h (last_byte %b, rejected %b)", data, last, rejected);
        mismatches++;
        return;
      end
      want = pending_bytes.pop_front();
      if (data !== want.data) begin
        $error("frame_byte: expected %02h, actual %02h", want.data, data);
        mismatches++;
      end
      if (last !== want.last) begin
        $error("last_byte: expected %b, actual %b", want.last, last);
        mismatches++;
      end
      if (rejected !== want.rejected) begin
        $error("rejected: expected %b, actual %b", want.rejected, rejected);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] blk_num_i = '0;
  logic [7:0]  status_code_i = '0;
  logic [63:0] commit_ofs_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [7:0]  frame_byte_o;
  logic        last_byte_o;
  logic        rejected_o;

  // phase flags set by the stimulus process, read by both sides
  logic calm = 1'b0;          // neither side idles
  logic eager = 1'b0;         // sender offers back to back
  logic hold_off_req = 1'b0;  // ask the receiver for one long hold-off

  ack_byte_ledger ledger;

  ack_frame_builder_crc32 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .blk_num_i     (blk_num_i),
    .status_code_i (status_code_i),
    .commit_ofs_i  (commit_ofs_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o),
    .rejected_o    (rejected_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // idle length: mostly none, often a short one, now and then a long one
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // mostly well-formed statuses, the rest any byte at all
  function automatic logic [7:0] pick_status();
    if ($urandom_range(0, 99) >= 75) return 8'($urandom_range(0, 255));
    unique case ($urandom_range(0, 2))
      0:       return ackfb_pkg::StatusAck;
      1:       return ackfb_pkg::StatusNak;
      default: return ackfb_pkg::StatusCan;
    endcase
  endfunction

  // offers one request transaction and returns at the edge that accepts it;
  // valid stays high into the next call when no gap is chosen
  task automatic send_request(input logic [31:0] idx, input logic [7:0] st,
                              input logic [63:0] off);
    int unsigned gap;
    gap = (calm || eager) ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    blk_num_i     <= idx;
    status_code_i <= st;
    commit_ofs_i  <= off;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(idx, st, off);
  endtask

  // receiver: checks each accepted frame byte, then picks next cycle's stall
  initial begin
    int unsigned stall_run;
    logic        hold_served;
    stall_run   = 0;
    hold_served = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        ledger.check_byte(frame_byte_o, last_byte_o, rejected_o);
      end
      if (hold_off_req && !hold_served) begin
        hold_served = 1'b1;
        stall_run   = HoldOffCycles;
      end else if (stall_run == 0 && !calm && $urandom_range(0, 3) == 0) begin
        stall_run = pick_idle();
      end
      if (stall_run != 0) begin
        out_stall_i <= 1'b1;
        stall_run--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // stimulus
  initial begin
    logic [31:0] idx;
    logic [7:0]  st;
    logic [63:0] off;
    ledger = new;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, each allowed status, rejects around each one
    send_request(32'h0000_0000, ackfb_pkg::StatusAck, 64'h0000_0000_0000_0000);
    send_request(32'hFFFF_FFFF, ackfb_pkg::StatusNak, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(32'hAAAA_AAAA, ackfb_pkg::StatusCan, 64'h5555_5555_5555_5555);
    send_request(32'h5555_5555, ackfb_pkg::StatusAck, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(32'h0123_4567, ackfb_pkg::StatusNak, 64'h0011_2233_4455_6677);
    send_request(32'h8000_0001, ackfb_pkg::StatusCan, 64'h8000_0000_0000_0001);
    send_request(32'h0000_0000, 8'h00, 64'h0000_0000_0000_0000);
    send_request(32'hFFFF_FFFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(32'h1234_5678, ackfb_pkg::StatusAck - 8'd1, 64'h1);
    send_request(32'h1234_5678, ackfb_pkg::StatusAck + 8'd1, 64'h2);
    send_request(32'h1234_5678, ackfb_pkg::StatusNak - 8'd1, 64'h3);
    send_request(32'h1234_5678, ackfb_pkg::StatusNak + 8'd1, 64'h4);
    send_request(32'h1234_5678, ackfb_pkg::StatusCan - 8'd1, 64'h5);
    send_request(32'h1234_5678, ackfb_pkg::StatusCan + 8'd1, 64'h6);
    // high bit set over an allowed low pattern must still reject
    send_request(32'h1234_5678, ackfb_pkg::StatusAck | 8'h80, 64'h7);
    // reject right between two frames
    send_request(32'hDEAD_BEEF, ackfb_pkg::StatusCan, 64'hFEDC_BA98_7654_3210);
    send_request(32'hDEAD_BEEF, 8'h42, 64'hFEDC_BA98_7654_3210);
    send_request(32'hCAFE_F00D, ackfb_pkg::StatusAck, 64'h0F0F_0F0F_F0F0_F0F0);

    // random: a hold-off while the sender keeps pushing, later a gap-free stretch
    for (int n = 0; n < RandomItems; n++) begin
      if (n == 30) begin
        hold_off_req <= 1'b1;
        eager        <= 1'b1;
      end
      if (n == 46) eager <= 1'b0;
      if (n == 90) calm <= 1'b1;
      if (n == 120) calm <= 1'b0;
      idx = $urandom;
      off = {$urandom, $urandom};
      st  = pick_status();
      send_request(idx, st, off);
    end
    in_valid_i <= 1'b0;

    while (ledger.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d frames and %0d rejected requests, %0d frame bytes checked",
             ledger.frames_noted, ledger.rejects_noted, ledger.bytes_checked);
    $display("run: random gaps on both sides, one %0d-cycle output hold-off, one gap-free span",
             HoldOffCycles);
    if (ledger.mismatches == 0 && ledger.pending_bytes.size() == 0) begin
      $display("ack_frame_builder_crc32: match");
    end else begin
      $display("ack_frame_builder_crc32: mismatch");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("run: timed out with %0d frame bytes outstanding", ledger.pending_bytes.size());
    $display("ack_frame_builder_crc32: mismatch");
    $finish;
  end

endmodule
